// File: src/pgc_pkg.sv
// Package: widths, constants, types and the arctangent table of the go-to-goal controller.
`default_nettype none
package pgc_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // CORDIC datapath widths
  localparam int CW  = 38;        // x/y vector width
  localparam int ZW  = 21;        // angle accumulator, Q16 radians
  localparam int MBW = 17;        // second multiplier operand
  localparam int PW  = CW + MBW;  // product width

  localparam logic signed [ZW-1:0] PI_Q16     = 21'sd205887;
  localparam logic signed [18:0]   PI_Q12     = 19'sd12868;
  localparam logic signed [18:0]   TWO_PI_Q12 = 19'sd25736;
  localparam logic signed [MBW-1:0] KINV_Q16  = 17'sd39797;

  // configuration register indexes
  localparam logic [2:0] REG_DIST_GAIN    = 3'd0;
  localparam logic [2:0] REG_BEARING_GAIN = 3'd1;
  localparam logic [2:0] REG_FINAL_GAIN   = 3'd2;
  localparam logic [2:0] REG_DIST_TOL     = 3'd3;
  localparam logic [2:0] REG_ANGLE_TOL    = 3'd4;

  typedef enum logic [1:0] {
    OP_GOAL = 2'd0,
    OP_POSE = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GQ0,
    ST_GQ1,
    ST_GQ2,
    ST_GQ3,
    ST_GQ4,
    ST_CSTART,
    ST_CWAIT,
    ST_DIST,
    ST_DEC,
    ST_BR,
    ST_SPD,
    ST_MA,
    ST_MB,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] ang;
    logic signed [CW-1:0] mag;
  } cord_res_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] k);
    logic [16:0] r;
    unique case (k)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30386;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/pgc_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle and scaled magnitude.
`default_nettype none
module pgc_cordic #(
  parameter int unsigned Steps = pgc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [pgc_pkg::CW-1:0] x_i,
  input  wire logic signed [pgc_pkg::CW-1:0] y_i,
  output pgc_pkg::cord_res_t                 res_o
);
  import pgc_pkg::*;

  localparam int CntW = $clog2(Steps + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic                 zero_q, zero_d;
  logic [4:0]           k;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign k  = 5'(cnt_q);
  assign xs = x_q >>> k;
  assign ys = y_q >>> k;
  assign at = signed'(ZW'(atan_q16(k)));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    if (start_i) begin
      zero_d = (x_i == '0) && (y_i == '0);
      cnt_d  = '0;
      busy_d = 1'b1;
      if (x_i < 0) begin
        z_d = (y_i >= 0) ? PI_Q16 : -PI_Q16;
        x_d = -x_i;
        y_d = -y_i;
      end else begin
        z_d = '0;
        x_d = x_i;
        y_d = y_i;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign res_o.done = done_q;
  assign res_o.ang  = zero_q ? '0 : z_q;
  assign res_o.mag  = x_q;

endmodule
`default_nettype wire

// File: src/polar_go_to_goal_controller.sv
// Top level: polar go-to-goal controller with a shared multiplier and iterative CORDIC.
//
// Input stream (s_axis): one request per item. tuser carries the opcode (goal update,
// pose update, control tick); tdata carries position, pose heading and goal quaternion.
// Output stream (m_axis): one result per control tick: linear and angular speed in tdata,
// the stop flag in tuser. Goal and pose requests give no result; opcode 3 is dropped.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i in the same cycle;
// only write while no request is in flight.
//
// Sequencing: a pose request is stored and the sequencer stays idle. A goal request keeps
// s_axis_tready low for four products on the shared multiplier, then one atan2 on the
// CORDIC. A tick runs the CORDIC, the distance and bearing steps and, unless it stops,
// the speed and turn-rate products; the CORDIC run dominates (one micro-rotation per
// cycle). s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; goal and pose requests are taken while it waits,
// a later tick holds in its last step until the register frees.
// Reset clears goal, pose, stored turn rate and arming, and loads default gains and tolerances.
`default_nettype none
module polar_go_to_goal_controller #(
  parameter int unsigned CORDIC_STEPS = pgc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], quat_x[95:80], quat_y[111:96],
  // quat_z[127:112], quat_w[143:128]
  input  wire logic [143:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // linear_speed[30:0], angular_speed[46:31], zero pad[47]
  output logic [47:0]       m_axis_tdata,
  // stopped[0]
  output logic [0:0]        m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [30:0]  cfg_wdata_i
);
  import pgc_pkg::*;

  function automatic logic signed [16:0] q16_to_q12(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + ZW'(8);
    return signed'(t[ZW-1:4]);
  endfunction

  // truncated remainder by 2pi, then fold into [-pi, pi]
  function automatic logic signed [18:0] wrap_turn(input logic signed [18:0] a);
    logic signed [18:0] r;
    r = a;
    if (a >= TWO_PI_Q12)       r = a - TWO_PI_Q12;
    else if (a <= -TWO_PI_Q12) r = a + TWO_PI_Q12;
    if (r > PI_Q12)            r = r - TWO_PI_Q12;
    else if (r < -PI_Q12)      r = r + TWO_PI_Q12;
    return r;
  endfunction

  // configuration
  logic [15:0] dist_gain_q, bear_gain_q, fin_gain_q;
  logic [30:0] dist_tol_q;
  logic [14:0] ang_tol_q;

  // controller state
  state_e             state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic signed [31:0] goal_px_q, goal_px_d, goal_py_q, goal_py_d;
  logic signed [31:0] pose_px_q, pose_px_d, pose_py_q, pose_py_d;
  logic signed [15:0] goal_ang_q, goal_ang_d, pose_ang_q, pose_ang_d;
  logic               armed_q, armed_d;
  logic signed [15:0] last_turn_q, last_turn_d;

  // datapath
  logic signed [15:0]  qx_q, qy_q, qz_q, qw_q, qx_d, qy_d, qz_d, qw_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, acc_q, acc_d;
  logic [33:0]          dist_q, dist_d;
  logic signed [18:0]   alpha_q, alpha_d, beta_q, beta_d;
  logic [30:0]          res_v_q, res_v_d;
  logic signed [15:0]   res_w_q, res_w_d;
  logic                 res_stop_q, res_stop_d;
  logic                 out_vld_q, out_vld_d;
  logic [30:0]          out_v_q, out_v_d;
  logic signed [15:0]   out_w_q, out_w_d;
  logic                 out_stop_q, out_stop_d;

  // shared multiplier
  logic signed [CW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_q, prod_d;

  logic      cord_start;
  cord_res_t cord_res;

  logic               accept;
  logic signed [15:0] h_in, h_wrap;
  logic signed [16:0] phi;
  logic signed [16:0] ang_err, ang_err_abs;
  logic               stop_br;
  logic signed [CW-1:0] s_sum, w_full;
  logic               out_free;

  pgc_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .x_i    (cx_q),
    .y_i    (cy_q),
    .res_o  (cord_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cord_start    = (state_q == ST_CSTART);
  assign out_free      = !out_vld_q || m_axis_tready;

  assign h_in   = signed'(s_axis_tdata[79:64]);
  assign h_wrap = (h_in >= 16'sd12868) ? 16'(h_in - 16'sd25736) :
                  (h_in < -16'sd12868) ? 16'(h_in + 16'sd25736) : h_in;

  assign phi         = q16_to_q12(cord_res.ang);
  assign ang_err     = 17'(goal_ang_q) - 17'(pose_ang_q);
  assign ang_err_abs = (ang_err < 0) ? -ang_err : ang_err;
  assign stop_br     = (dist_q < {3'b0, dist_tol_q}) || !armed_q;
  assign s_sum       = acc_q - prod_q[CW-1:0];
  assign w_full      = (s_sum + CW'(8192)) >>> 14;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GQ0: begin mul_a = CW'(qw_q); mul_b = MBW'(qz_q); end
      ST_GQ1: begin mul_a = CW'(qx_q); mul_b = MBW'(qy_q); end
      ST_GQ2: begin mul_a = CW'(qz_q); mul_b = MBW'(qz_q); end
      ST_GQ3: begin mul_a = CW'(qy_q); mul_b = MBW'(qy_q); end
      ST_DIST: begin mul_a = cord_res.mag; mul_b = KINV_Q16; end
      ST_BR: begin mul_a = signed'({4'b0, dist_q}); mul_b = signed'({1'b0, dist_gain_q}); end
      ST_SPD: begin mul_a = CW'(alpha_q); mul_b = signed'({1'b0, bear_gain_q}); end
      ST_MA: begin mul_a = CW'(beta_q); mul_b = signed'({1'b0, fin_gain_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == OP_GOAL)      state_d = ST_GQ0;
          else if (s_axis_tuser == OP_TICK) state_d = ST_CSTART;
        end
      end
      ST_GQ0:    state_d = ST_GQ1;
      ST_GQ1:    state_d = ST_GQ2;
      ST_GQ2:    state_d = ST_GQ3;
      ST_GQ3:    state_d = ST_GQ4;
      ST_GQ4:    state_d = ST_CSTART;
      ST_CSTART: state_d = ST_CWAIT;
      ST_CWAIT: begin
        if (cord_res.done) state_d = (op_q == OP_GOAL) ? ST_IDLE : ST_DIST;
      end
      ST_DIST:   state_d = ST_DEC;
      ST_DEC:    state_d = ST_BR;
      ST_BR:     state_d = stop_br ? ST_OUT : ST_SPD;
      ST_SPD:    state_d = ST_MA;
      ST_MA:     state_d = ST_MB;
      ST_MB:     state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and state updates
  always_comb begin
    op_d        = op_q;
    goal_px_d   = goal_px_q;
    goal_py_d   = goal_py_q;
    pose_px_d   = pose_px_q;
    pose_py_d   = pose_py_q;
    goal_ang_d  = goal_ang_q;
    pose_ang_d  = pose_ang_q;
    armed_d     = armed_q;
    last_turn_d = last_turn_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    qz_d        = qz_q;
    qw_d        = qw_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    acc_d       = acc_q;
    dist_d      = dist_q;
    alpha_d     = alpha_q;
    beta_d      = beta_q;
    res_v_d     = res_v_q;
    res_w_d     = res_w_q;
    res_stop_d  = res_stop_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_v_d     = out_v_q;
    out_w_d     = out_w_q;
    out_stop_d  = out_stop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = s_axis_tuser;
          unique case (s_axis_tuser)
            OP_GOAL: begin
              goal_px_d = signed'(s_axis_tdata[31:0]);
              goal_py_d = signed'(s_axis_tdata[63:32]);
              qx_d      = signed'(s_axis_tdata[95:80]);
              qy_d      = signed'(s_axis_tdata[111:96]);
              qz_d      = signed'(s_axis_tdata[127:112]);
              qw_d      = signed'(s_axis_tdata[143:128]);
            end
            OP_POSE: begin
              pose_px_d  = signed'(s_axis_tdata[31:0]);
              pose_py_d  = signed'(s_axis_tdata[63:32]);
              pose_ang_d = h_wrap;
            end
            OP_TICK: begin
              cx_d = CW'(goal_px_q) - CW'(pose_px_q);
              cy_d = CW'(goal_py_q) - CW'(pose_py_q);
            end
            default: ;
          endcase
        end
      end
      ST_GQ1: acc_d = prod_q[CW-1:0];
      ST_GQ2: cy_d  = (acc_q + prod_q[CW-1:0]) <<< 1;
      ST_GQ3: acc_d = prod_q[CW-1:0];
      ST_GQ4: cx_d  = (CW'(1) <<< 28) - ((acc_q + prod_q[CW-1:0]) <<< 1);
      ST_CWAIT: begin
        if (cord_res.done && op_q == OP_GOAL) begin
          goal_ang_d = phi[15:0];
          armed_d    = 1'b1;
        end
      end
      ST_DEC: dist_d = prod_q[49:16];
      ST_BR: begin
        if (stop_br) begin
          res_v_d    = '0;
          res_w_d    = last_turn_q;
          res_stop_d = 1'b1;
          armed_d    = 1'b0;
          if (ang_err_abs < signed'({2'b0, ang_tol_q})) last_turn_d = '0;
        end else begin
          alpha_d = wrap_turn(19'(phi) - 19'(pose_ang_q));
        end
      end
      ST_SPD: begin
        res_v_d = (|prod_q[PW-1:47]) ? '1 : prod_q[46:16];
        beta_d  = wrap_turn(19'(goal_ang_q) - 19'(pose_ang_q) - alpha_q);
      end
      ST_MA: acc_d = prod_q[CW-1:0];
      ST_MB: begin
        if (w_full > CW'(32767))       res_w_d = 16'sh7FFF;
        else if (w_full < -CW'(32768)) res_w_d = -16'sh8000;
        else                           res_w_d = w_full[15:0];
        last_turn_d = (w_full > CW'(32767)) ? 16'sh7FFF :
                      (w_full < -CW'(32768)) ? -16'sh8000 : w_full[15:0];
        res_stop_d  = 1'b0;
      end
      ST_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_v_d    = res_v_q;
          out_w_d    = res_w_q;
          out_stop_d = res_stop_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      goal_px_q   <= '0;
      goal_py_q   <= '0;
      pose_px_q   <= '0;
      pose_py_q   <= '0;
      goal_ang_q  <= '0;
      pose_ang_q  <= '0;
      armed_q     <= 1'b0;
      last_turn_q <= '0;
      out_vld_q   <= 1'b0;
      dist_gain_q <= 16'd19661;
      bear_gain_q <= 16'd13107;
      fin_gain_q  <= 16'd8192;
      dist_tol_q  <= 31'd655;
      ang_tol_q   <= 15'd25;
    end else begin
      state_q     <= state_d;
      goal_px_q   <= goal_px_d;
      goal_py_q   <= goal_py_d;
      pose_px_q   <= pose_px_d;
      pose_py_q   <= pose_py_d;
      goal_ang_q  <= goal_ang_d;
      pose_ang_q  <= pose_ang_d;
      armed_q     <= armed_d;
      last_turn_q <= last_turn_d;
      out_vld_q   <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_DIST_GAIN:    dist_gain_q <= cfg_wdata_i[15:0];
          REG_BEARING_GAIN: bear_gain_q <= cfg_wdata_i[15:0];
          REG_FINAL_GAIN:   fin_gain_q  <= cfg_wdata_i[15:0];
          REG_DIST_TOL:     dist_tol_q  <= cfg_wdata_i;
          REG_ANGLE_TOL:    ang_tol_q   <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    qz_q       <= qz_d;
    qw_q       <= qw_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    acc_q      <= acc_d;
    dist_q     <= dist_d;
    alpha_q    <= alpha_d;
    beta_q     <= beta_d;
    res_v_q    <= res_v_d;
    res_w_q    <= res_w_d;
    res_stop_q <= res_stop_d;
    out_v_q    <= out_v_d;
    out_w_q    <= out_w_d;
    out_stop_q <= out_stop_d;
    prod_q     <= prod_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_w_q, out_v_q};
  assign m_axis_tuser  = out_stop_q;

  // the goal is disarmed only by the stop branch
  a_disarm_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(armed_q) |-> $past(state_q) == ST_BR)
    else $error("goal disarmed outside stop branch");

  // a stopped result never carries linear speed
  a_stop_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[30:0] == '0))
    else $error("stopped result with nonzero linear speed");

  // leaving the result state always presents a result
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> m_axis_tvalid)
    else $error("result lost on output load");

  // no request taken while the sequencer waits on the CORDIC
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWAIT) |-> !s_axis_tready)
    else $error("request accepted during CORDIC run");

endmodule
`default_nettype wire
